// ----- rtl/swcl_pkg.sv -----
// ---------------------------------------------------------------------------
// swcl_pkg
// Shared types and constants for the stopwatch / countdown timer with laps.
// ---------------------------------------------------------------------------
package swcl_pkg;

    localparam int SWCL_LAP_DEPTH  = 4;
    localparam int SWCL_TIME_BITS  = 48;

    localparam int SWCL_SHOWN_W    = 48;
    localparam int SWCL_LAPCNT_W   = 3;
    localparam int SWCL_LAPCNT_MAX = 7;

    localparam int SWCL_SECS_W     = 13;
    localparam int SWCL_SECS_MIN   = 5;
    localparam int SWCL_SECS_MAX   = 5999;
    localparam int SWCL_SECS_RESET = 300;
    localparam int SWCL_US_PER_SEC = 1000000;
    localparam int SWCL_DUR_W      = 33;

    // shown / 10000 = (shown >> 4) / 625, then / 100, / 60, / 60
    localparam int SWCL_PRE_SHIFT  = 4;
    localparam int SWCL_STEPS      = 8;
    localparam int SWCL_D1_W       = SWCL_SHOWN_W - SWCL_PRE_SHIFT;
    localparam int SWCL_D1_DIV     = 625;
    localparam int SWCL_D1_QW      = 35;
    localparam int SWCL_D2_DIV     = 100;
    localparam int SWCL_D2_QW      = 29;
    localparam int SWCL_D3_DIV     = 60;
    localparam int SWCL_D3_QW      = 23;
    localparam int SWCL_D4_DIV     = 60;
    localparam int SWCL_D4_QW      = 17;

    typedef enum logic [1:0]
    {
        OP_POLL   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_LAP    = 2'd2,
        OP_RESET  = 2'd3
    } swcl_op_t;

    typedef enum logic [1:0]
    {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_PAUSED  = 2'd2,
        ST_DONE    = 2'd3
    } swcl_status_t;

    typedef struct packed
    {
        logic [SWCL_SHOWN_W-1:0]  shown_us;
        swcl_status_t             status;
        logic                     beep;
        logic [SWCL_LAPCNT_W-1:0] lap_total;
        logic                     lap_taken;
        logic [SWCL_SHOWN_W-1:0]  lap_time;
    } swcl_info_t;

    typedef struct packed
    {
        swcl_info_t info;
        logic [6:0] centiseconds;
    } swcl_side3_t;

    typedef struct packed
    {
        swcl_info_t info;
        logic [6:0] centiseconds;
        logic [5:0] seconds_part;
    } swcl_side4_t;

endpackage

// ----- rtl/swcl_cdiv.sv -----
// ---------------------------------------------------------------------------
// swcl_cdiv
// Pipelined long division by a constant, a few quotient bits per stage,
// with a sideband that travels alongside each item.
// ---------------------------------------------------------------------------
module swcl_cdiv
    import swcl_pkg::*;
#(
    parameter int WIDTH   = SWCL_D1_W,
    parameter int DIVISOR = SWCL_D1_DIV,
    parameter int QW      = SWCL_D1_QW,
    parameter int STEPS   = SWCL_STEPS,
    parameter int SIDE_W  = $bits(swcl_info_t)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_stall,
    input  logic [WIDTH-1:0]            dividend,
    input  logic [SIDE_W-1:0]           up_side,
    output logic                        dn_valid,
    input  logic                        dn_stall,
    output logic [QW-1:0]               quotient,
    output logic [$clog2(DIVISOR)-1:0]  remainder,
    output logic [SIDE_W-1:0]           dn_side
);

    localparam int RW   = $clog2(DIVISOR);
    localparam int NSTG = (WIDTH + STEPS - 1) / STEPS;
    localparam logic [RW:0] DIV_X = (RW + 1)'(DIVISOR);

    logic              vld_reg  [NSTG];
    logic [WIDTH-1:0]  dvd_reg  [NSTG];
    logic [RW-1:0]     rem_reg  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];
    logic              hold     [NSTG];

    for (genvar s = 0; s < NSTG; s++)
    begin : g_stg
        localparam int FIRST = s * STEPS;
        localparam int CNT   = (WIDTH - FIRST < STEPS) ? (WIDTH - FIRST) : STEPS;

        logic              pv;
        logic [WIDTH-1:0]  pdvd;
        logic [WIDTH-1:0]  ndvd;
        logic [RW-1:0]     prem;
        logic [RW-1:0]     nrem;
        logic [SIDE_W-1:0] pside;

        if (s == 0)
        begin : g_head
            assign pv    = up_valid;
            assign pdvd  = dividend;
            assign prem  = '0;
            assign pside = up_side;
        end
        else
        begin : g_body
            assign pv    = vld_reg[s-1];
            assign pdvd  = dvd_reg[s-1];
            assign prem  = rem_reg[s-1];
            assign pside = side_reg[s-1];
        end

        if (s == NSTG - 1)
        begin : g_last
            assign hold[s] = vld_reg[s] && dn_stall;
        end
        else
        begin : g_mid
            assign hold[s] = vld_reg[s] && hold[s+1];
        end

        always_comb
        begin
            logic [RW:0] t;
            logic        qb;
            t    = '0;
            qb   = 1'b0;
            ndvd = pdvd;
            nrem = prem;
            for (int k = 0; k < CNT; k++)
            begin
                t  = {nrem, ndvd[WIDTH-1]};
                qb = (t >= DIV_X);
                if (qb)
                begin
                    t = t - DIV_X;
                end
                nrem = t[RW-1:0];
                ndvd = {ndvd[WIDTH-2:0], qb};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (!hold[s])
            begin
                vld_reg[s] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (pv && !hold[s])
            begin
                dvd_reg[s]  <= ndvd;
                rem_reg[s]  <= nrem;
                side_reg[s] <= pside;
            end
        end
    end

    assign up_stall  = hold[0];
    assign dn_valid  = vld_reg[NSTG-1];
    assign quotient  = dvd_reg[NSTG-1][QW-1:0];
    assign remainder = rem_reg[NSTG-1];
    assign dn_side   = side_reg[NSTG-1];

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> ({1'b0, remainder} < DIV_X))
        else $error("remainder not below divisor");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        up_stall |-> (dn_valid && dn_stall))
        else $error("upstream stalled while pipeline can drain");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && !up_stall) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

endmodule

// ----- rtl/stopwatch_countdown_with_laps_top.sv -----
// ---------------------------------------------------------------------------
// stopwatch_countdown_with_laps_top
// Stopwatch and countdown timer with lap counting; each command yields the
// shown time split into hours, minutes, seconds and centiseconds.
// ---------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall) carries opcode, now_us and
//   countdown_view; a transfer happens when item_valid is high and item_stall
//   low. Every item gives exactly one result on the result channel
//   (result_valid / result_stall), in order.
//   cfg channel (cfg_valid / cfg_ready) writes countdown_seconds, clamped to
//   5..5999; cfg_ready is always high and a write also clears run, time,
//   beep and lap state. Write only while no item is in flight.
//   From item transfer to result_valid an item passes one input register,
//   one state-update stage, one stage forming the shown time and 18
//   long-division stages (up to 8 quotient bits per stage) for the split.
//   Throughput is one item per cycle while item_stall is low. Timer state
//   updates once per item, so back-to-back items see each other's effect.
//   When result_stall is held, results wait in the pipeline, bubbles close
//   up and item_stall rises only once every stage holds an item.
//   Reset empties the pipeline, sets the duration to 300 s and clears all
//   timing state; no clearing pass is needed.
// ---------------------------------------------------------------------------
module stopwatch_countdown_with_laps_top
    import swcl_pkg::*;
#(
    parameter int LAP_DEPTH = SWCL_LAP_DEPTH,
    parameter int TIME_BITS = SWCL_TIME_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               opcode,
    input  logic [47:0]              now_us,
    input  logic                     countdown_view,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [SWCL_SECS_W-1:0]   countdown_seconds,

    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [SWCL_SHOWN_W-1:0]  shown_us,
    output logic [16:0]              hours,
    output logic [5:0]               minutes,
    output logic [5:0]               seconds_part,
    output logic [6:0]               centiseconds,
    output logic [1:0]               status,
    output logic                     beep,
    output logic [SWCL_LAPCNT_W-1:0] lap_total,
    output logic                     lap_taken,
    output logic [SWCL_SHOWN_W-1:0]  lap_time
);

    localparam int TB    = TIME_BITS;
    localparam int FW    = $clog2(LAP_DEPTH + 1);
    localparam int FX    = (FW > SWCL_LAPCNT_W) ? FW : SWCL_LAPCNT_W;
    localparam int XW    = (SWCL_DUR_W > TB) ? SWCL_DUR_W : TB;
    localparam int CAP_W = (SWCL_SHOWN_W > TB) ? SWCL_SHOWN_W : TB;
    localparam logic [TB-1:0] TMAX      = '1;
    localparam logic [TB-1:0] DUR_RESET = TB'(SWCL_SECS_RESET * SWCL_US_PER_SEC);

    typedef struct packed
    {
        logic [TB-1:0]            el;
        logic                     cv;
        logic                     ge;
        swcl_status_t             status;
        logic                     beep;
        logic [SWCL_LAPCNT_W-1:0] lap_total;
        logic                     lap_taken;
        logic [SWCL_SHOWN_W-1:0]  lap_time;
    } res_t;

    function automatic logic [SWCL_SHOWN_W-1:0] sat_shown(input logic [TB-1:0] v);
        logic [CAP_W-1:0] vx;
        vx = CAP_W'(v);
        if (vx > CAP_W'({SWCL_SHOWN_W{1'b1}}))
        begin
            return '1;
        end
        return vx[SWCL_SHOWN_W-1:0];
    endfunction

    // input register
    logic          in_vld_reg;
    swcl_op_t      op_reg;
    logic [TB-1:0] now_reg;
    logic          cv_reg;

    // timer state
    logic          run_reg,    run_next;
    logic [TB-1:0] acc_reg,    acc_next;
    logic [TB-1:0] start_reg,  start_next;
    logic [TB-1:0] paused_reg, paused_next;
    logic          beeped_reg, beeped_next;
    logic [FW-1:0] fill_reg,   fill_next;
    logic [TB-1:0] dur_reg,    dur_next;

    res_t          res_reg, res_next;
    logic          res_vld_reg;
    swcl_info_t    shw_reg, shw_next;
    logic          shw_vld_reg;

    logic          in_hold, res_hold, shw_hold, fire;

    // configuration
    logic [SWCL_SECS_W-1:0] secs_c;
    logic [SWCL_DUR_W-1:0]  prod;
    logic [XW-1:0]          prod_x;
    logic [TB-1:0]          cfg_dur;

    // per-item datapath
    logic [TB:0]   diff;
    logic [TB-1:0] delta;
    logic [TB:0]   sum;
    logic [TB-1:0] e0;
    logic          run1, beeped1;
    logic [TB-1:0] acc1, paused1, start1;
    logic [FW-1:0] fill1;
    logic          taken_c;
    logic [TB-1:0] lap_val;
    logic [TB-1:0] el;
    logic          ge, expire, done;
    logic          run_f;
    logic [TB-1:0] acc_f, paused_f;
    logic [TB-1:0] shown_full;

    // divider chain
    logic                      d1_stall, d1_valid, d2_stall, d2_valid;
    logic                      d3_stall, d3_valid, d4_stall;
    logic [SWCL_D1_QW-1:0]     q1;
    logic [SWCL_D2_QW-1:0]     q2;
    logic [SWCL_D3_QW-1:0]     q3;
    logic [$clog2(SWCL_D1_DIV)-1:0] r1;
    logic [6:0]                r2;
    logic [5:0]                r3;
    logic [$bits(swcl_info_t)-1:0]  s1, s2;
    swcl_info_t                i2;
    swcl_side3_t               side3;
    logic [$bits(swcl_side3_t)-1:0] s3;
    swcl_side4_t               side4;

    assign cfg_ready  = 1'b1;
    assign in_hold    = in_vld_reg && res_hold;
    assign res_hold   = res_vld_reg && shw_hold;
    assign shw_hold   = shw_vld_reg && d1_stall;
    assign fire       = in_vld_reg && !res_hold;
    assign item_stall = in_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_hold)
        begin
            in_vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !in_hold)
        begin
            op_reg  <= swcl_op_t'(opcode);
            now_reg <= TB'(now_us);
            cv_reg  <= countdown_view;
        end
    end

    always_comb
    begin
        secs_c = countdown_seconds;
        if (countdown_seconds < SWCL_SECS_W'(SWCL_SECS_MIN))
        begin
            secs_c = SWCL_SECS_W'(SWCL_SECS_MIN);
        end
        else if (countdown_seconds > SWCL_SECS_W'(SWCL_SECS_MAX))
        begin
            secs_c = SWCL_SECS_W'(SWCL_SECS_MAX);
        end
        prod    = SWCL_DUR_W'(secs_c) * SWCL_DUR_W'(SWCL_US_PER_SEC);
        prod_x  = XW'(prod);
        cfg_dur = (prod_x > XW'(TMAX)) ? TMAX : TB'(prod_x);
    end

    // elapsed time before the command
    always_comb
    begin
        diff  = {1'b0, now_reg} - {1'b0, start_reg};
        delta = diff[TB] ? '0 : diff[TB-1:0];
        sum   = {1'b0, acc_reg} + {1'b0, delta};
        e0    = !run_reg ? paused_reg : (sum[TB] ? TMAX : sum[TB-1:0]);
    end

    always_comb
    begin
        run1    = run_reg;
        acc1    = acc_reg;
        paused1 = paused_reg;
        start1  = start_reg;
        beeped1 = beeped_reg;
        fill1   = fill_reg;
        taken_c = 1'b0;
        lap_val = '0;
        case (op_reg)
            OP_TOGGLE:
            begin
                if (run_reg)
                begin
                    paused1 = e0;
                    acc1    = e0;
                    run1    = 1'b0;
                end
                else
                begin
                    if (cv_reg && acc_reg >= dur_reg)
                    begin
                        acc1    = '0;
                        beeped1 = 1'b0;
                    end
                    start1 = now_reg;
                    run1   = 1'b1;
                end
            end
            OP_LAP:
            begin
                if (!cv_reg && run_reg)
                begin
                    taken_c = 1'b1;
                    lap_val = e0;
                    if (fill_reg < FW'(LAP_DEPTH))
                    begin
                        fill1 = fill_reg + FW'(1);
                    end
                end
            end
            OP_RESET:
            begin
                run1    = 1'b0;
                acc1    = '0;
                paused1 = '0;
                beeped1 = 1'b0;
                fill1   = '0;
            end
            default:
            begin
            end
        endcase

        // after the command only a running poll or lap still needs the live sum
        el       = run1 ? ((op_reg == OP_TOGGLE) ? acc1 : e0) : paused1;
        ge       = el >= dur_reg;
        expire   = cv_reg && ge && run1;
        run_f    = run1 && !expire;
        acc_f    = expire ? dur_reg : acc1;
        paused_f = expire ? dur_reg : paused1;
        done     = cv_reg && ge && (acc_f >= dur_reg);

        res_next.el        = el;
        res_next.cv        = cv_reg;
        res_next.ge        = ge;
        res_next.beep      = expire && !beeped1;
        res_next.lap_taken = taken_c;
        res_next.lap_time  = sat_shown(lap_val);
        res_next.lap_total = (FX'(fill1) > FX'(SWCL_LAPCNT_MAX)) ?
                             SWCL_LAPCNT_W'(SWCL_LAPCNT_MAX) : SWCL_LAPCNT_W'(fill1);
        if (done)
        begin
            res_next.status = ST_DONE;
        end
        else if (run_f)
        begin
            res_next.status = ST_RUNNING;
        end
        else if (paused_f != '0)
        begin
            res_next.status = ST_PAUSED;
        end
        else
        begin
            res_next.status = ST_READY;
        end
    end

    always_comb
    begin
        run_next    = run_reg;
        acc_next    = acc_reg;
        start_next  = start_reg;
        paused_next = paused_reg;
        beeped_next = beeped_reg;
        fill_next   = fill_reg;
        dur_next    = dur_reg;
        if (cfg_valid)
        begin
            dur_next    = cfg_dur;
            run_next    = 1'b0;
            acc_next    = '0;
            paused_next = '0;
            beeped_next = 1'b0;
            fill_next   = '0;
        end
        else if (fire)
        begin
            run_next    = run_f;
            acc_next    = acc_f;
            start_next  = start1;
            paused_next = paused_f;
            beeped_next = beeped1 || expire;
            fill_next   = fill1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            acc_reg    <= '0;
            start_reg  <= '0;
            paused_reg <= '0;
            beeped_reg <= 1'b0;
            fill_reg   <= '0;
            dur_reg    <= DUR_RESET;
        end
        else
        begin
            run_reg    <= run_next;
            acc_reg    <= acc_next;
            start_reg  <= start_next;
            paused_reg <= paused_next;
            beeped_reg <= beeped_next;
            fill_reg   <= fill_next;
            dur_reg    <= dur_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (!res_hold)
        begin
            res_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // shown time: elapsed, or remaining in countdown view
    always_comb
    begin
        if (!res_reg.cv)
        begin
            shown_full = res_reg.el;
        end
        else if (res_reg.ge)
        begin
            shown_full = '0;
        end
        else
        begin
            shown_full = dur_reg - res_reg.el;
        end
        shw_next.shown_us  = sat_shown(shown_full);
        shw_next.status    = res_reg.status;
        shw_next.beep      = res_reg.beep;
        shw_next.lap_total = res_reg.lap_total;
        shw_next.lap_taken = res_reg.lap_taken;
        shw_next.lap_time  = res_reg.lap_time;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shw_vld_reg <= 1'b0;
        end
        else if (!shw_hold)
        begin
            shw_vld_reg <= res_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_vld_reg && !shw_hold)
        begin
            shw_reg <= shw_next;
        end
    end

    // centiseconds total, remainder of the low four bits dropped with r1
    swcl_cdiv #(
        .WIDTH   (SWCL_D1_W),
        .DIVISOR (SWCL_D1_DIV),
        .QW      (SWCL_D1_QW),
        .STEPS   (SWCL_STEPS),
        .SIDE_W  ($bits(swcl_info_t))
    ) u_div_cs (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (shw_vld_reg),
        .up_stall  (d1_stall),
        .dividend  (shw_reg.shown_us[SWCL_SHOWN_W-1:SWCL_PRE_SHIFT]),
        .up_side   (shw_reg),
        .dn_valid  (d1_valid),
        .dn_stall  (d2_stall),
        .quotient  (q1),
        .remainder (r1),
        .dn_side   (s1)
    );

    swcl_cdiv #(
        .WIDTH   (SWCL_D1_QW),
        .DIVISOR (SWCL_D2_DIV),
        .QW      (SWCL_D2_QW),
        .STEPS   (SWCL_STEPS),
        .SIDE_W  ($bits(swcl_info_t))
    ) u_div_sec (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (d1_valid),
        .up_stall  (d2_stall),
        .dividend  (q1),
        .up_side   (s1),
        .dn_valid  (d2_valid),
        .dn_stall  (d3_stall),
        .quotient  (q2),
        .remainder (r2),
        .dn_side   (s2)
    );

    assign i2                 = s2;
    assign side3.info         = i2;
    assign side3.centiseconds = r2;

    swcl_cdiv #(
        .WIDTH   (SWCL_D2_QW),
        .DIVISOR (SWCL_D3_DIV),
        .QW      (SWCL_D3_QW),
        .STEPS   (SWCL_STEPS),
        .SIDE_W  ($bits(swcl_side3_t))
    ) u_div_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (d2_valid),
        .up_stall  (d3_stall),
        .dividend  (q2),
        .up_side   (side3),
        .dn_valid  (d3_valid),
        .dn_stall  (d4_stall),
        .quotient  (q3),
        .remainder (r3),
        .dn_side   (s3)
    );

    swcl_side3_t side3_out;
    logic [$bits(swcl_side4_t)-1:0] s4;

    assign side3_out = s3;

    swcl_cdiv #(
        .WIDTH   (SWCL_D3_QW),
        .DIVISOR (SWCL_D4_DIV),
        .QW      (SWCL_D4_QW),
        .STEPS   (SWCL_STEPS),
        .SIDE_W  ($bits(swcl_side4_t))
    ) u_div_hr (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (d3_valid),
        .up_stall  (d4_stall),
        .dividend  (q3),
        .up_side   ({side3_out.info, side3_out.centiseconds, r3}),
        .dn_valid  (result_valid),
        .dn_stall  (result_stall),
        .quotient  (hours),
        .remainder (minutes),
        .dn_side   (s4)
    );

    assign side4        = s4;
    assign shown_us     = side4.info.shown_us;
    assign seconds_part = side4.seconds_part;
    assign centiseconds = side4.centiseconds;
    assign status       = side4.info.status;
    assign beep         = side4.info.beep;
    assign lap_total    = side4.info.lap_total;
    assign lap_taken    = side4.info.lap_taken;
    assign lap_time     = side4.info.lap_time;

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_DONE) |-> (shown_us == '0))
        else $error("done status with nonzero shown time");

    a_beep_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && beep) |-> (status == ST_DONE))
        else $error("beep without countdown done");

    a_lap_running: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && lap_taken) |-> (status == ST_RUNNING))
        else $error("lap recorded while not running");

    a_lap_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !lap_taken) |-> (lap_time == '0))
        else $error("lap time without a lap");

    a_cfg_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> !run_reg)
        else $error("duration write left the timer running");

endmodule
